// File: sv/gult_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and microcode table for the graph update log table.
// Depends on nothing; every other file of the block imports it.

package gult_pkg;

   // Field widths fixed by the interface.
   localparam int VTX_W      = 10;
   localparam int CMD_W      = 2;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int LOG_W      = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LIST   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

   // Destination kinds of an insert.
   localparam logic [KIND_W-1:0] DK_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] DK_ADD    = 2'd2;

   // Kinds held in the upper bits of a vertex log entry.
   localparam logic [1:0] LOG_NONE  = 2'd0;
   localparam logic [1:0] LOG_EDGE  = 2'd1;
   localparam logic [1:0] LOG_DEL   = 2'd2;
   localparam logic [1:0] LOG_ADDED = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOG_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd2;

   // Microprogram steps.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_INSERT,
      ST_LIST_HEAD,
      ST_LIST_WALK,
      ST_CHECK,
      ST_SPARE
   } step_type;

   // Jump conditions of a control word.
   typedef enum logic [2:0] {
      JMP_ALWAYS,
      JMP_IF_CLEAR_DONE,
      JMP_DISPATCH,
      JMP_IF_HEAD_NULL,
      JMP_IF_WALK_LAST
   } jump_type;

   // Format of the result beat built in a step.
   typedef enum logic [2:0] {
      ROW_INSERT,
      ROW_EMPTY,
      ROW_WALK,
      ROW_CHECK,
      ROW_ZERO
   } row_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic     accept;
      logic     clear;
      logic     insert;
      logic     emit;
      logic     pool_head;
      logic     pool_walk;
      row_type  row;
      jump_type jump;
      step_type target_t;
      step_type target_f;
   } ucode_type;

   // Controls from the sequencer to the datapath; insert, emit and pool_rd are gated by the stall.
   typedef struct packed {
      logic    ready;
      logic    clear;
      logic    insert;
      logic    emit;
      logic    pool_rd;
      logic    pool_walk;
      row_type row;
   } ctrl_type;

   // Conditions from the datapath back to the sequencer.
   typedef struct packed {
      logic clear_done;
      logic head_null;
      logic walk_last;
      logic out_busy;
   } cond_type;

   // Fields of one input beat.
   typedef struct packed {
      logic [KIND_W-1:0] dst_kind;
      logic [VTX_W-1:0]  other_vertex;
      logic [VTX_W-1:0]  vertex;
      logic [CMD_W-1:0]  command;
   } req_type;

   // Fields of one result beat.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VTX_W-1:0]    neighbor;
      logic                neighbor_valid;
      logic                last;
      logic                changed;
      logic                deleted_node;
      logic                new_node;
      logic                has_new_log;
   } rsp_type;

   // The microprogram itself.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type word;
      word = '0;
      word.jump     = JMP_ALWAYS;
      word.target_t = ST_FETCH;
      word.target_f = ST_FETCH;
      word.row      = ROW_ZERO;
      unique case (step)
         ST_CLEAR: begin
            word.clear    = 1'b1;
            word.jump     = JMP_IF_CLEAR_DONE;
            word.target_f = ST_CLEAR;
         end
         ST_FETCH: begin
            word.accept   = 1'b1;
            word.jump     = JMP_DISPATCH;
            word.target_f = ST_FETCH;
         end
         ST_INSERT: begin
            word.insert = 1'b1;
            word.emit   = 1'b1;
            word.row    = ROW_INSERT;
         end
         ST_LIST_HEAD: begin
            word.emit      = 1'b1;
            word.pool_head = 1'b1;
            word.row       = ROW_EMPTY;
            word.jump      = JMP_IF_HEAD_NULL;
            word.target_f  = ST_LIST_WALK;
         end
         ST_LIST_WALK: begin
            word.emit      = 1'b1;
            word.pool_walk = 1'b1;
            word.row       = ROW_WALK;
            word.jump      = JMP_IF_WALK_LAST;
            word.target_f  = ST_LIST_WALK;
         end
         ST_CHECK: begin
            word.emit = 1'b1;
            word.row  = ROW_CHECK;
         end
         ST_SPARE: begin
            word.emit = 1'b1;
            word.row  = ROW_ZERO;
         end
         default: begin
            word.jump = JMP_ALWAYS;
         end
      endcase
      return word;
   endfunction

   // Entry step of each command.
   function automatic step_type dispatch(logic [CMD_W-1:0] command);
      step_type step;
      unique case (command)
         CMD_INSERT: step = ST_INSERT;
         CMD_LIST:   step = ST_LIST_HEAD;
         CMD_CHECK:  step = ST_CHECK;
         default:    step = ST_SPARE;
      endcase
      return step;
   endfunction

endpackage

// File: sv/gult_sequencer.sv
`timescale 1ns / 1ps
// Step counter and microcode decode of the graph update log table.
// Depends on gult_pkg for the control word table and the control structs.

module gult_sequencer
   import gult_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   input  cond_type         cond,
   output ctrl_type         ctrl
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      go;
   logic      accept;

   // Step register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   // Fetch the control word, stall while a result beat cannot be placed,
   // and resolve the jump.
   always_comb begin
      word    = ucode_rom(step_ff);
      go      = !(word.emit && cond.out_busy);
      accept  = word.accept && req_valid;
      step_in = step_ff;
      if (go) begin
         unique case (word.jump)
            JMP_ALWAYS:        step_in = word.target_t;
            JMP_IF_CLEAR_DONE: step_in = cond.clear_done ? word.target_t : word.target_f;
            JMP_DISPATCH:      step_in = accept ? dispatch(req_command) : word.target_f;
            JMP_IF_HEAD_NULL:  step_in = cond.head_null ? word.target_t : word.target_f;
            JMP_IF_WALK_LAST:  step_in = cond.walk_last ? word.target_t : word.target_f;
            default:           step_in = ST_FETCH;
         endcase
      end

      ctrl.ready     = word.accept;
      ctrl.clear     = word.clear;
      ctrl.insert    = word.insert && go;
      ctrl.emit      = word.emit && go;
      ctrl.pool_rd   = (word.pool_head || word.pool_walk) && go;
      ctrl.pool_walk = word.pool_walk;
      ctrl.row       = word.row;
   end

endmodule

// File: sv/gult_datapath.sv
`timescale 1ns / 1ps
// Tables, counters and result register of the graph update log table.
// Depends on gult_pkg; driven by the control struct from gult_sequencer.

module gult_datapath
   import gult_pkg::*;
#(
   parameter int VERTEX_COUNT = 1024,
   parameter int LOG_DEPTH    = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  logic     req_valid,
   input  req_type  req,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp,
   output cond_type cond
);

   localparam int VA = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int PA = $clog2(LOG_DEPTH);
   localparam int CW = PA + 1;
   localparam logic [CW-1:0] LINK_NULL  = {1'b1, {PA{1'b0}}};
   localparam logic [CW-1:0] POOL_LIMIT = CW'(LOG_DEPTH);
   localparam logic [VA-1:0] CLEAR_LAST = VA'(VERTEX_COUNT - 1);

   // Vertex tables and reverse-edge pool.
   logic [LOG_W-1:0] vlog_mem  [VERTEX_COUNT];
   logic [CW-1:0]    lhead_mem [VERTEX_COUNT];
   logic [CW-1:0]    pnext_mem [LOG_DEPTH];
   logic [VTX_W-1:0] pnbr_mem  [LOG_DEPTH];

   // Item registers and registered read data.
   logic [VTX_W-1:0]  vtx_ff;
   logic [VTX_W-1:0]  oth_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [LOG_W-1:0]  vlog_rd_ff;
   logic [CW-1:0]     lhead_rd_ff;
   logic [CW-1:0]     pnext_rd_ff;
   logic [VTX_W-1:0]  pnbr_rd_ff;

   // Control state.
   logic [VA-1:0] clr_ff;
   logic [VA-1:0] clr_in;
   logic [CW-1:0] log_count_ff;
   logic [CW-1:0] log_count_in;
   logic [CW-1:0] pool_tail_ff;
   logic [CW-1:0] pool_tail_in;
   logic          flag_ff;
   logic          flag_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       row;

   logic          accept;
   logic [VA-1:0] rd_vaddr;
   logic [VA-1:0] rd_haddr;
   logic [PA-1:0] pool_addr;
   logic [PA-1:0] tail_idx;
   logic [1:0]    ins_code;
   logic          is_edge;
   logic          vtx_ok;
   logic          oth_ok;
   logic          in_range;
   logic          no_log;
   logic          log_full;
   logic          pool_full;
   logic          log_we;
   logic          push;
   logic          flag_set;
   logic [STATUS_W-1:0] ins_status;
   logic [LOG_W-1:0]    log_wdata;
   logic [LOG_W-1:0]    chk_entry;
   logic [1:0]          chk_kind;
   logic                head_null;
   logic                walk_last;
   logic                emit_fire;

   assign accept    = ctrl.ready && req_valid;
   assign rd_vaddr  = VA'(req.vertex);
   assign rd_haddr  = VA'((req.command == CMD_INSERT) ? req.other_vertex : req.vertex);
   assign pool_addr = ctrl.pool_walk ? pnext_rd_ff[PA-1:0] : lhead_rd_ff[PA-1:0];
   assign tail_idx  = pool_tail_ff[PA-1:0];

   // Capture the item and read both vertex tables on the accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         vtx_ff      <= req.vertex;
         oth_ff      <= req.other_vertex;
         kind_ff     <= req.dst_kind;
         vlog_rd_ff  <= vlog_mem[rd_vaddr];
         lhead_rd_ff <= lhead_mem[rd_haddr];
      end
   end

   // Vertex table writes: the clearing pass after reset, then inserts.
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         vlog_mem[clr_ff]  <= '0;
         lhead_mem[clr_ff] <= LINK_NULL;
      end else begin
         if (log_we) begin
            vlog_mem[VA'(vtx_ff)] <= log_wdata;
         end
         if (push) begin
            lhead_mem[VA'(oth_ff)] <= {1'b0, tail_idx};
         end
      end
   end

   // Pool read for the list walk, one entry per step.
   always_ff @(posedge clock) begin
      if (ctrl.pool_rd) begin
         pnext_rd_ff <= pnext_mem[pool_addr];
         pnbr_rd_ff  <= pnbr_mem[pool_addr];
      end
   end

   // Pool write: push the new reverse edge in front of the old head.
   always_ff @(posedge clock) begin
      if (push) begin
         pnext_mem[tail_idx] <= lhead_rd_ff;
         pnbr_mem[tail_idx]  <= vtx_ff;
      end
   end

   // Insert decisions, made from the entries read on the accepted beat.
   always_comb begin
      if (kind_ff == DK_DELETE) begin
         ins_code = LOG_DEL;
      end else if (kind_ff == DK_ADD) begin
         ins_code = LOG_ADDED;
      end else begin
         ins_code = LOG_EDGE;
      end
      is_edge   = (ins_code == LOG_EDGE);
      vtx_ok    = int'(vtx_ff) < VERTEX_COUNT;
      oth_ok    = int'(oth_ff) < VERTEX_COUNT;
      in_range  = vtx_ok && (!is_edge || oth_ok);
      no_log    = (vlog_rd_ff[LOG_W-1:VTX_W] == LOG_NONE);
      log_full  = no_log && (log_count_ff >= POOL_LIMIT);
      pool_full = (pool_tail_ff >= POOL_LIMIT);
      log_we    = ctrl.insert && in_range && !log_full;
      push      = log_we && is_edge && !pool_full;
      flag_set  = log_we && !(is_edge && pool_full);
      log_wdata = {ins_code, is_edge ? oth_ff : {VTX_W{1'b0}}};

      if (!in_range) begin
         ins_status = STATUS_OK;
      end else if (log_full) begin
         ins_status = STATUS_LOG_FULL;
      end else if (is_edge && pool_full) begin
         ins_status = STATUS_POOL_FULL;
      end else begin
         ins_status = STATUS_OK;
      end
   end

   // Counters and the sticky new-log flag.
   always_comb begin
      clr_in       = ctrl.clear ? clr_ff + 1'b1 : clr_ff;
      log_count_in = (log_we && no_log) ? log_count_ff + 1'b1 : log_count_ff;
      pool_tail_in = push ? pool_tail_ff + 1'b1 : pool_tail_ff;
      flag_in      = flag_ff || flag_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         log_count_ff <= '0;
         pool_tail_ff <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         log_count_ff <= log_count_in;
         pool_tail_ff <= pool_tail_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Status of the queried vertex and of the list walk.
   always_comb begin
      chk_entry = vtx_ok ? vlog_rd_ff : '0;
      chk_kind  = chk_entry[LOG_W-1:VTX_W];
      head_null = !vtx_ok || lhead_rd_ff[PA];
      walk_last = pnext_rd_ff[PA];
   end

   // Build the result beat of the current step.
   always_comb begin
      row                = '0;
      row.last           = 1'b1;
      row.has_new_log    = flag_in;
      case (ctrl.row)
         ROW_INSERT: begin
            row.status = ins_status;
         end
         ROW_WALK: begin
            row.neighbor       = pnbr_rd_ff;
            row.neighbor_valid = 1'b1;
            row.last           = walk_last;
         end
         ROW_CHECK: begin
            row.changed      = (chk_kind != LOG_NONE) &&
                               ((chk_kind != LOG_EDGE) || (chk_entry[VTX_W-1:0] != oth_ff));
            row.deleted_node = (chk_kind == LOG_DEL);
            row.new_node     = (chk_kind == LOG_ADDED);
         end
         default: begin
            row.last = 1'b1;
         end
      endcase
   end

   // Result register: loads a beat when empty or while the previous one leaves.
   assign emit_fire    = ctrl.emit && ((ctrl.row != ROW_EMPTY) || head_null);
   assign rsp_valid_in = emit_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_ff <= row;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;
   assign cond.clear_done = (clr_ff == CLEAR_LAST);
   assign cond.head_null  = head_null;
   assign cond.walk_last  = walk_last;
   assign cond.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

// File: sv/graph_update_log_table_unit.sv
`timescale 1ns / 1ps
// Each result beat is registered at the end of the step that builds it, and a stalled
// result holds that step. Insert, check, spare and an empty list take a fetch step, then an
// update or reply step; a list takes fetch and head steps, then a walk step per neighbour, as the
// pool walk reads one entry per step; the first neighbour beat is built in the first walk step.
// Reset: synchronous; a clearing pass over all VERTEX_COUNT vertex entries follows, with req_tready low.
// Holds the streaming ports and packs beats; depends on gult_pkg, gult_sequencer, gult_datapath.

module graph_update_log_table_unit
   import gult_pkg::*;
#(
   parameter int VERTEX_COUNT = 1024,
   parameter int LOG_DEPTH    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // vertex, other_vertex, dst_kind, zero pad
   input  logic [CMD_W-1:0]      req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // status, neighbor, changed, deleted_node,
                                             // new_node, has_new_log
   output logic                  rsp_tuser,  // neighbor_valid
   output logic                  rsp_tlast   // last
);

   ctrl_type ctrl;
   cond_type cond;
   req_type  req;
   rsp_type  rsp;

   // Unpack the input beat.
   always_comb begin
      req.command      = req_tuser;
      req.vertex       = req_tdata[VTX_W-1:0];
      req.other_vertex = req_tdata[2*VTX_W-1:VTX_W];
      req.dst_kind     = req_tdata[2*VTX_W+KIND_W-1:2*VTX_W];
   end

   gult_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_command (req_tuser),
      .cond        (cond),
      .ctrl        (ctrl)
   );

   gult_datapath #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .LOG_DEPTH    (LOG_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_valid (req_tvalid),
      .req       (req),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .cond      (cond)
   );

   // Pack the result beat.
   assign req_tready = ctrl.ready;
   assign rsp_tdata  = {rsp.has_new_log, rsp.new_node, rsp.deleted_node, rsp.changed,
                        rsp.neighbor, rsp.status};
   assign rsp_tuser  = rsp.neighbor_valid;
   assign rsp_tlast  = rsp.last;

endmodule

// File: sv/gult_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the graph update log table, bound to the top level.
// Depends on gult_pkg and graph_update_log_table_unit.

module gult_checker
   import gult_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // Reset starts the clearing pass, so no beat is taken straight after it.
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input taken directly after reset");

   // One item at a time: the cycle after an accepted beat is spent on it.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken in back-to-back cycles");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result beat changed while stalled");

   // Only a list walk gives several beats, and each of them carries a neighbour.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> rsp_tuser)
      else $error("non-final beat without a neighbour");

   // An insert failure is a single beat with no neighbour.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[STATUS_W-1:0] != STATUS_OK)) |-> (rsp_tlast && !rsp_tuser))
      else $error("failure status on a list beat");

endmodule

bind graph_update_log_table_unit gult_checker u_checker (.*);

// File: sim/graph_update_log_table_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the graph update log table, predicts every result beat and compares it.
// Depends on gult_pkg for the beat layouts and the command, kind and status codes.

module graph_update_log_table_checker
   import gult_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // vertex, other_vertex, dst_kind, zero pad
   input  logic [CMD_W-1:0]      req_tuser,  // command
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // status, neighbor, changed, deleted_node,
                                             // new_node, has_new_log
   input  logic                  rsp_tuser,  // neighbor_valid
   input  logic                  rsp_tlast,  // last
   output int                    fail_count,
   output int                    outstanding
);

   localparam int VTX_COUNT  = 1024;
   localparam int POOL_DEPTH = 64;

   // Mirror of the block's tables; a set top bit of a link means the list ends there.
   logic [LOG_W-1:0] vertex_log    [VTX_COUNT];
   logic [6:0]       list_head     [VTX_COUNT];
   logic [6:0]       pool_next     [POOL_DEPTH];
   logic [VTX_W-1:0] pool_neighbor [POOL_DEPTH];
   int               logged_vertices;
   int               pool_used;
   logic             new_log_seen;

   rsp_type awaited_beats[$];
   int      error_total = 0;
   int      pending = 0;

   assign fail_count  = error_total;
   assign outstanding = pending;

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_total++;
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Appends one predicted beat behind those already awaited.
   task automatic queue_beat(input rsp_type beat);
      awaited_beats.insert(awaited_beats.size(), beat);
   endtask

   // Updates the vertex log and the reverse-edge pool for one insert; returns its status.
   function automatic logic [STATUS_W-1:0] apply_insert(input req_type item);
      logic [1:0] code;
      code = (item.dst_kind == DK_DELETE) ? LOG_DEL :
             (item.dst_kind == DK_ADD)    ? LOG_ADDED : LOG_EDGE;
      if (vertex_log[item.vertex][11:10] == LOG_NONE) begin
         if (logged_vertices >= POOL_DEPTH) return STATUS_LOG_FULL;
         logged_vertices++;
      end
      vertex_log[item.vertex] = {code, (code == LOG_EDGE) ? item.other_vertex : {VTX_W{1'b0}}};
      if (code == LOG_EDGE) begin
         // The log has changed already, but a full pool leaves the flag alone.
         if (pool_used >= POOL_DEPTH) return STATUS_POOL_FULL;
         pool_next[pool_used]                 = list_head[item.other_vertex];
         pool_neighbor[pool_used]             = item.vertex;
         list_head[item.other_vertex]         = 7'(pool_used);
         pool_used++;
      end
      new_log_seen = 1'b1;
      return STATUS_OK;
   endfunction

   // Works out every result beat of one accepted request and queues it.
   task automatic predict_table_beats(input req_type item);
      rsp_type     row;
      logic [11:0] entry;
      logic [6:0]  link;
      logic [6:0]  nxt;
      int          n;
      logic        fin;
      row      = '0;
      row.last = 1'b1;
      case (item.command)
         CMD_INSERT: begin
            row.status      = apply_insert(item);
            row.has_new_log = new_log_seen;
            queue_beat(row);
         end
         CMD_LIST: begin
            row.has_new_log = new_log_seen;
            link = list_head[item.vertex];
            if (link[6]) begin
               queue_beat(row);
            end else begin
               // Newest first, one beat per neighbour, last on the oldest.
               n   = 0;
               fin = 1'b0;
               while (!fin) begin
                  nxt                = pool_next[link[5:0]];
                  fin                = nxt[6] || (n + 1 >= POOL_DEPTH);
                  row.neighbor       = pool_neighbor[link[5:0]];
                  row.neighbor_valid = 1'b1;
                  row.last           = fin;
                  queue_beat(row);
                  n++;
                  link = nxt;
               end
            end
         end
         CMD_CHECK: begin
            entry            = vertex_log[item.vertex];
            row.changed      = (entry[11:10] != LOG_NONE) &&
                               (entry[11:10] != LOG_EDGE || entry[9:0] != item.other_vertex);
            row.deleted_node = (entry[11:10] == LOG_DEL);
            row.new_node     = (entry[11:10] == LOG_ADDED);
            row.has_new_log  = new_log_seen;
            queue_beat(row);
         end
         default: begin
            row.has_new_log = new_log_seen;
            queue_beat(row);
         end
      endcase
   endtask

   // Result beats are compared before the request of the same edge is predicted: a beat can
   // never belong to a request accepted at the same edge.
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      req_type item;
      if (reset) begin
         for (int i = 0; i < VTX_COUNT; i++) begin
            vertex_log[i] = '0;
            list_head[i]  = 7'h40;
         end
         logged_vertices = 0;
         pool_used       = 0;
         new_log_seen    = 1'b0;
         awaited_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got                = '0;
            got.status         = rsp_tdata[1:0];
            got.neighbor       = rsp_tdata[11:2];
            got.changed        = rsp_tdata[12];
            got.deleted_node   = rsp_tdata[13];
            got.new_node       = rsp_tdata[14];
            got.has_new_log    = rsp_tdata[15];
            got.neighbor_valid = rsp_tuser;
            got.last           = rsp_tlast;
            if (awaited_beats.size() == 0) begin
               report_mismatch("result beat with nothing awaited, tdata", rsp_tdata, 0);
            end else begin
               want = awaited_beats.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.neighbor != want.neighbor)
                  report_mismatch("neighbor", got.neighbor, want.neighbor);
               if (got.neighbor_valid != want.neighbor_valid)
                  report_mismatch("neighbor_valid", got.neighbor_valid, want.neighbor_valid);
               if (got.last != want.last)
                  report_mismatch("last", got.last, want.last);
               if (got.changed != want.changed)
                  report_mismatch("changed", got.changed, want.changed);
               if (got.deleted_node != want.deleted_node)
                  report_mismatch("deleted_node", got.deleted_node, want.deleted_node);
               if (got.new_node != want.new_node)
                  report_mismatch("new_node", got.new_node, want.new_node);
               if (got.has_new_log != want.has_new_log)
                  report_mismatch("has_new_log", got.has_new_log, want.has_new_log);
            end
         end
         if (req_tvalid && req_tready) begin
            item.command      = req_tuser;
            item.vertex       = req_tdata[9:0];
            item.other_vertex = req_tdata[19:10];
            item.dst_kind     = req_tdata[21:20];
            predict_table_beats(item);
         end
      end
      pending <= awaited_beats.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Top of the graph update log table bench: clock, reset, request and stall stimulus, verdict.
// Depends on gult_pkg, graph_update_log_table_unit and graph_update_log_table_checker.

module tb;
   import gult_pkg::*;

   // Insert kinds that the package leaves unnamed: ordinary edge and the unused code.
   localparam logic [KIND_W-1:0] DK_EDGE  = 2'd0;
   localparam logic [KIND_W-1:0] DK_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // vertex, other_vertex, dst_kind, zero pad
   logic [CMD_W-1:0]      req_tuser = '0;  // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // status, neighbor, changed, deleted_node,
                                           // new_node, has_new_log
   logic                  rsp_tuser;       // neighbor_valid
   logic                  rsp_tlast;       // last
   int                    mismatches;
   int                    outstanding;
   int                    idle_odds = 3;   // 0 means no idling on either side

   graph_update_log_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   graph_update_log_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (mismatches),
      .outstanding (outstanding)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Generous ceiling: the clearing pass plus every item at its longest walk and worst stalls.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic req_type make_item(input logic [CMD_W-1:0] command,
                                         input int vertex, input int other_vertex,
                                         input logic [KIND_W-1:0] dst_kind);
      req_type item;
      item.command      = command;
      item.vertex       = VTX_W'(vertex);
      item.other_vertex = VTX_W'(other_vertex);
      item.dst_kind     = dst_kind;
      return item;
   endfunction

   // Sources come mostly from a set of 80 vertices, so the log fills up and checks hit logs.
   function automatic int source_vertex();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 79) * 12 + 7;
   endfunction

   // Destinations crowd onto four vertices so that the reverse lists grow long.
   function automatic int hot_vertex();
      int hot [4] = '{0, 341, 682, 1023};
      return hot[$urandom_range(0, 3)];
   endfunction

   // Offers one request beat, holds it until accepted, then perhaps idles for a burst.
   task automatic send_item(input req_type item);
      int gap;
      req_tdata  <= {2'b00, item.dst_kind, item.other_vertex, item.vertex};
      req_tuser  <= item.command;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result side stalls in bursts while idling is allowed.
   initial begin : result_stalls
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds * 3) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_type item;
      int      pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty tables, field extremes, every command and kind, overwritten logs.
      send_item(make_item(CMD_CHECK, 0, 0, DK_EDGE));
      send_item(make_item(CMD_LIST, 0, 0, DK_EDGE));
      send_item(make_item(CMD_LIST, 1023, 1023, DK_SPARE));
      send_item(make_item(CMD_SPARE, 1023, 1023, DK_SPARE));
      send_item(make_item(CMD_INSERT, 0, 1023, DK_EDGE));
      send_item(make_item(CMD_INSERT, 1023, 0, DK_EDGE));
      // The unused kind behaves as an ordinary edge.
      send_item(make_item(CMD_INSERT, 5, 1023, DK_SPARE));
      send_item(make_item(CMD_LIST, 1023, 0, DK_EDGE));
      send_item(make_item(CMD_LIST, 0, 0, DK_EDGE));
      send_item(make_item(CMD_CHECK, 0, 1023, DK_EDGE));
      send_item(make_item(CMD_CHECK, 0, 5, DK_EDGE));
      send_item(make_item(CMD_INSERT, 7, 1023, DK_DELETE));
      send_item(make_item(CMD_CHECK, 7, 1023, DK_EDGE));
      send_item(make_item(CMD_INSERT, 8, 0, DK_ADD));
      send_item(make_item(CMD_CHECK, 8, 0, DK_EDGE));
      // A vertex that already has a log takes a new mark without a new log slot.
      send_item(make_item(CMD_INSERT, 0, 1023, DK_ADD));
      send_item(make_item(CMD_CHECK, 0, 1023, DK_EDGE));
      send_item(make_item(CMD_CHECK, 1023, 0, DK_EDGE));
      send_item(make_item(CMD_INSERT, 1023, 1023, DK_EDGE));
      send_item(make_item(CMD_LIST, 1023, 0, DK_EDGE));

      // Random: half inserts, mostly onto hot destinations, so both the log and the pool fill up.
      for (int k = 0; k < 210; k++) begin
         if (k % 40 == 0) begin
            pick      = $urandom_range(0, 2);
            idle_odds = (pick == 0) ? 0 : (pick == 1) ? 2 : 5;
         end
         if (k >= 170) idle_odds = 0;
         item.command      = CMD_SPARE;
         item.vertex       = VTX_W'($urandom);
         item.other_vertex = VTX_W'($urandom);
         item.dst_kind     = KIND_W'($urandom);
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            item.command = CMD_INSERT;
            item.vertex  = VTX_W'(source_vertex());
            if ($urandom_range(0, 9) != 0) item.other_vertex = VTX_W'(hot_vertex());
            if ($urandom_range(0, 4) != 0) item.dst_kind = DK_EDGE;
         end else if (pick < 15) begin
            item.command = CMD_LIST;
            if ($urandom_range(0, 4) != 0) item.vertex = VTX_W'(hot_vertex());
         end else if (pick < 19) begin
            item.command = CMD_CHECK;
            item.vertex  = VTX_W'(source_vertex());
            if ($urandom_range(0, 1) == 0) item.other_vertex = VTX_W'(hot_vertex());
         end
         send_item(item);
      end
      req_tvalid <= 1'b0;

      // Let the last acceptance reach the checker, then drain.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/gult_pkg.sv
sv/gult_sequencer.sv
sv/gult_datapath.sv
sv/graph_update_log_table_unit.sv
sv/gult_checker.sv
sim/graph_update_log_table_checker.sv
sim/tb.sv
